// ===== rtl/pcmd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmd_pkg
// Shared types and constants for the PWM capture to motor drive block.
// ----------------------------------------------------------------------------
package pcmd_pkg;

    localparam int TIME_W      = 16;
    localparam int DUTY_W      = 14;
    localparam int DIV_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int CHANNELS_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_TOP     = 1'd1;

    localparam logic [15:0] PERIOD_RST = 16'd2040;
    localparam logic [15:0] TOP_RST    = 16'd8561;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;
    localparam logic [DUTY_W-1:0] REV_LIMIT = 14'd4900;
    localparam logic [DUTY_W-1:0] FWD_LIMIT = 14'd5100;
    localparam logic [15:0]       SCALE_K   = 16'd49000;
    localparam logic [15:0]       FWD_OFFS  = 16'd11000;

    typedef struct packed {
        logic              fall;
        logic [TIME_W-1:0] ton;
    } cap_evt_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD1,
        ST_DIV1,
        ST_SCALE,
        ST_LOAD2,
        ST_DIV2,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/pcmd_capture.sv =====
// ----------------------------------------------------------------------------
// pcmd_capture
// Per-channel edge tracking: stores rising timestamps, measures on-time.
// ----------------------------------------------------------------------------
module pcmd_capture
    import pcmd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              channel,
    input  logic [TIME_W-1:0] capture_time,
    input  logic [TIME_W-1:0] period,
    output cap_evt_t          evt
);

    logic [TIME_W-1:0] rise_reg [CHANNELS];
    logic [CHANNELS-1:0] await_reg;

    logic [CHANNELS-1:0] hit;
    logic                ch_ok;
    logic [TIME_W-1:0]   sel_rise;
    logic                sel_await;
    logic [TIME_W+1:0]   wsum;
    logic [TIME_W-1:0]   ton;

    always_comb
    begin
        sel_rise  = '0;
        sel_await = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            hit[i] = (32'(channel) == i);
            if (hit[i])
            begin
                sel_rise  = rise_reg[i];
                sel_await = await_reg[i];
            end
        end
        ch_ok = |hit;
    end

    always_comb
    begin
        wsum = (TIME_W+2)'(period) + (TIME_W+2)'(capture_time);
        if (capture_time > sel_rise)
            ton = capture_time - sel_rise;
        else if (wsum < (TIME_W+2)'(sel_rise))
            ton = '0;
        else
            ton = TIME_W'(wsum - (TIME_W+2)'(sel_rise));
    end

    assign evt.fall = accept && ch_ok && sel_await;
    assign evt.ton  = ton;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
                rise_reg[i] <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (hit[i])
                begin
                    if (!await_reg[i])
                        rise_reg[i] <= capture_time;
                    await_reg[i] <= !await_reg[i];
                end
            end
        end
    end

endmodule

// ===== rtl/pcmd_sdiv.sv =====
// ----------------------------------------------------------------------------
// pcmd_sdiv
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcmd_sdiv
    import pcmd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [15:0]      divisor,
    output div_stat_t        stat,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0] quo_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [16:0] rem_sh;
    logic        ge;
    logic [15:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? 16'(rem_sh - {1'b0, dvs_reg}) : rem_sh[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== rtl/pwm_capture_to_motor_drive_top.sv =====
// ----------------------------------------------------------------------------
// pwm_capture_to_motor_drive_top
// Capture timestamps in, duty and motor drive command out.
// ----------------------------------------------------------------------------
// A rising-edge beat is absorbed in the idle state and gives no output. A falling-
// edge beat passes through these steps: the on-time is measured, the bit-serial
// divider gives the duty, one multiply, the shared divider gives the compare
// value, plus load and output states (the braking case skips the second
// division). One beat is in flight at a time, and a new beat is taken while a
// finished result waits on the output register.
module pwm_capture_to_motor_drive_top
    import pcmd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TIME_W-1:0]     s_tdata,   // [15:0] capture_time
    input  logic                  s_tuser,   // [0] channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [13:0] duty, [14] forward, [15] brake,
                                             // [31:16] compare
    output logic                  m_tuser,   // [0] out_channel
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic [15:0]       period_reg, top_reg;
    logic [TIME_W-1:0] ton_reg;
    logic              ch_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic              fwd_reg, brk_reg;
    logic [DIV_W-1:0]  prod_reg;
    logic [15:0]       cmp_reg;

    logic              m_valid_reg;
    logic              out_ch_reg, out_fwd_reg, out_brk_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic [15:0]       out_cmp_reg;

    logic              in_fire;
    logic [15:0]       period_eff;
    cap_evt_t          evt;
    div_stat_t         div_stat;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [15:0]       div_divisor;
    logic [DIV_W-1:0]  div_q;
    logic [DUTY_W-1:0] duty_sat;
    logic              brk_w, fwd_w;
    logic [15:0]       six_d, num;
    logic              load_ton, load_duty, load_prod, load_cmp, load_zero, load_out;

    assign in_fire    = s_tvalid && s_tready;
    assign period_eff = (period_reg == '0) ? 16'd1 : period_reg;

    pcmd_capture #(
        .CHANNELS (CHANNELS)
    ) u_capture (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_fire),
        .channel      (s_tuser),
        .capture_time (s_tdata),
        .period       (period_eff),
        .evt          (evt)
    );

    pcmd_sdiv u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_comb
    begin
        duty_sat = (div_q > DIV_W'(DUTY_FULL)) ? DUTY_FULL : div_q[DUTY_W-1:0];
        brk_w    = (duty_reg >= REV_LIMIT) && (duty_reg <= FWD_LIMIT);
        fwd_w    = (duty_reg > FWD_LIMIT);
        six_d    = (16'(duty_reg) << 2) + (16'(duty_reg) << 1);
        num      = fwd_w ? (six_d - FWD_OFFS) : (SCALE_K - six_d);
    end

    always_comb
    begin
        state_next   = state_reg;
        load_ton     = 1'b0;
        load_duty    = 1'b0;
        load_prod    = 1'b0;
        load_cmp     = 1'b0;
        load_zero    = 1'b0;
        load_out     = 1'b0;
        div_start    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = SCALE_K;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_fire && evt.fall)
                begin
                    load_ton   = 1'b1;
                    state_next = ST_LOAD1;
                end
            end
            ST_LOAD1:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(ton_reg) * DIV_W'(DUTY_FULL);
                div_divisor  = period_eff;
                state_next   = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_stat.done)
                begin
                    load_duty  = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                load_prod = 1'b1;
                if (brk_w)
                begin
                    load_zero  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_LOAD2;
            end
            ST_LOAD2:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_stat.done)
                begin
                    load_cmp   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            top_reg    <= TOP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPTURE_PERIOD: period_reg <= cfg_wdata;
                CFG_OUTPUT_TOP:     top_reg    <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ton)
        begin
            ton_reg <= evt.ton;
            ch_reg  <= s_tuser;
        end
        if (load_duty)
            duty_reg <= duty_sat;
        if (load_prod)
        begin
            prod_reg <= DIV_W'(num) * DIV_W'(top_reg);
            fwd_reg  <= fwd_w;
            brk_reg  <= brk_w;
        end
        if (load_zero)
            cmp_reg <= '0;
        else if (load_cmp)
            cmp_reg <= div_q[15:0];
        if (load_out)
        begin
            out_ch_reg   <= ch_reg;
            out_duty_reg <= duty_reg;
            out_fwd_reg  <= fwd_reg;
            out_brk_reg  <= brk_reg;
            out_cmp_reg  <= cmp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tdata  = {out_cmp_reg, out_brk_reg, out_fwd_reg, out_duty_reg};

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_brake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && out_brk_reg |-> out_cmp_reg == '0)
        else $error("nonzero compare while braking");

    a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(out_fwd_reg && out_brk_reg))
        else $error("forward and brake both set");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> out_duty_reg <= DUTY_FULL)
        else $error("duty above full scale");

endmodule

// ===== tb/sv/pwm_capture_to_motor_drive_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_capture_to_motor_drive_top_test
// Streams rise/fall capture stamps on both channels through the block. Every
// accepted beat goes into a predictor of on-time, duty and drive. Each output
// beat is checked field by field against the oldest predicted drive result.
// The run goes through several period and full-scale settings, the extremes
// among them, with random gaps on the input and back-pressure on the output.
// ----------------------------------------------------------------------------
module pwm_capture_to_motor_drive_top_test;
    import pcmd_pkg::*;

    typedef struct {
        logic              out_channel;
        logic [DUTY_W-1:0] duty;
        logic              forward;
        logic              brake;
        logic [15:0]       compare;
    } drive_t;

    class motor_drive_predictor;
        logic [15:0] capture_period;
        logic [15:0] output_top;
        logic [15:0] rise_time[2];
        bit          await_fall[2];
        drive_t      expected_drive[$];
        int          errors;

        function new();
            capture_period = PERIOD_RST;
            output_top     = TOP_RST;
            rise_time      = '{16'd0, 16'd0};
            await_fall     = '{1'b0, 1'b0};
            errors         = 0;
        endfunction

        function int eff_period();
            return (capture_period == 0) ? 1 : int'(capture_period);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
            if (idx == CFG_CAPTURE_PERIOD)
                capture_period = value;
            else if (idx == CFG_OUTPUT_TOP)
                output_top = value;
        endfunction

        function void note_capture(bit ch, logic [15:0] stamp);
            longint per, ton, w, dq, s, cmp;
            drive_t res;
            if (!await_fall[ch]) begin
                rise_time[ch]  = stamp;
                await_fall[ch] = 1'b1;
                return;
            end
            await_fall[ch] = 1'b0;
            per = eff_period();
            if (stamp > rise_time[ch]) begin
                ton = longint'(stamp) - longint'(rise_time[ch]);
            end
            else begin
                w   = per - longint'(rise_time[ch]) + longint'(stamp);
                ton = (w < 0) ? 0 : w;
            end
            dq = (ton * 10000) / per;
            if (dq > 10000)
                dq = 10000;
            if (dq < 5000)
                s = 30000 - 6 * (5000 - dq);
            else if (dq > 5000)
                s = 70000 + 6 * (dq - 5000);
            else
                s = 50000;
            res.out_channel = ch;
            res.duty        = dq[DUTY_W-1:0];
            res.forward     = 1'b0;
            res.brake       = 1'b0;
            cmp             = 0;
            if (dq < 4900) begin
                cmp = ((49000 - s) * longint'(output_top)) / 49000;
            end
            else if (dq > 5100) begin
                res.forward = 1'b1;
                cmp = ((s - 51000) * longint'(output_top)) / 49000;
            end
            else begin
                res.brake = 1'b1;
            end
            res.compare = cmp[15:0];
            expected_drive.push_back(res);
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_drive(logic [31:0] data, logic user);
            drive_t exp_d;
            if (expected_drive.size() == 0) begin
                errors++;
                $display("%0t: unexpected drive beat, expected none actual data %h user %b",
                         $time, data, user);
                return;
            end
            exp_d = expected_drive.pop_front();
            compare_field("out_channel", exp_d.out_channel, user);
            compare_field("duty", exp_d.duty, data[13:0]);
            compare_field("forward", exp_d.forward, data[14]);
            compare_field("brake", exp_d.brake, data[15]);
            compare_field("compare", exp_d.compare, data[31:16]);
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TIME_W-1:0]     s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    motor_drive_predictor sb = new();
    int hold_reqs = 0;

    pwm_capture_to_motor_drive_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // starts and ends at a falling edge
    task automatic send_capture(bit ch, logic [15:0] stamp);
        s_tvalid <= 1'b1;
        s_tdata  <= stamp;
        s_tuser  <= ch;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_capture(ch, stamp);
        @(negedge clk);
    endtask

    task automatic idle(int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, value);
        @(negedge clk);
    endtask

    task automatic drain_results(int settle);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    function automatic logic [15:0] next_stamp(bit ch);
        int per, r, on, k, tgt, dlt;
        int targets[7] = '{0, 4899, 4900, 5000, 5100, 5101, 10000};
        per = sb.eff_period();
        k   = $urandom_range(0, 99);
        if (k < 15)
            return 16'($urandom_range(0, 65535));
        if (!sb.await_fall[ch])
            return 16'($urandom_range(0, per - 1));
        r = int'(sb.rise_time[ch]);
        if (k < 25)
        begin
            on = 0;
        end
        else if (k < 55)
        begin
            tgt = targets[$urandom_range(0, 6)];
            dlt = $urandom_range(0, 2);
            on  = int'((longint'(tgt) * per) / 10000) + dlt - 1;
            if (on < 0)
                on = 0;
        end
        else
        begin
            on = $urandom_range(0, per);
        end
        if (r < per)
            return 16'((r + on) % per);
        return 16'((r + on) & 16'hFFFF);
    endfunction

    // output side: random stall stretches, one long hold-off on request
    initial
    begin
        int mode, span, k, cyc, hold_left, holds_taken;
        m_tready    = 1'b0;
        span        = 0;
        cyc         = 0;
        hold_left   = 0;
        holds_taken = 0;
        mode        = 0;
        k           = 2;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_reqs != holds_taken)
            begin
                holds_taken = hold_reqs;
                hold_left   = 400;
                m_tready   <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(10, 150);
                    k    = $urandom_range(2, 6);
                end
                span--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ((cyc % k) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_drive(m_tdata, m_tuser);
    end

    initial
    begin
        int          ph, n, burst_left;
        bit          ch;
        logic [15:0] periods[8];
        logic [15:0] tops[8];
        periods   = '{16'd2040, 16'd65535, 16'd1, 16'd0,
                      16'd1000, 16'd37, 16'd0, 16'd5000};
        tops      = '{16'd8561, 16'd65535, 16'd1, 16'd1000,
                      16'd0, 16'd65535, 16'd0, 16'd12345};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_CAPTURE_PERIOD;
        cfg_wdata = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: equal stamps, wrap, wrap below zero, saturation
        send_capture(1'b0, 16'd0);
        send_capture(1'b0, 16'd0);
        send_capture(1'b1, 16'd100);
        send_capture(1'b1, 16'd50);
        send_capture(1'b0, 16'hFFFF);
        send_capture(1'b0, 16'd0);
        send_capture(1'b1, 16'd0);
        send_capture(1'b1, 16'hFFFF);
        drain_results(80);

        // period 10000 makes the duty equal to the on-time: deadband edges
        write_register(CFG_CAPTURE_PERIOD, 16'd10000);
        write_register(CFG_OUTPUT_TOP, 16'd65535);
        send_capture(1'b0, 16'd0);
        send_capture(1'b0, 16'd4899);
        send_capture(1'b1, 16'd0);
        send_capture(1'b1, 16'd4900);
        send_capture(1'b0, 16'd0);
        send_capture(1'b0, 16'd5000);
        send_capture(1'b1, 16'd0);
        send_capture(1'b1, 16'd5100);
        send_capture(1'b0, 16'd0);
        send_capture(1'b0, 16'd5101);
        send_capture(1'b1, 16'd0);
        send_capture(1'b1, 16'd10000);
        send_capture(1'b0, 16'd5);
        send_capture(1'b0, 16'd4);
        drain_results(80);

        for (ph = 0; ph < 8; ph++)
        begin
            if (ph == 6)
            begin
                periods[ph] = 16'($urandom_range(2, 65535));
                tops[ph]    = 16'($urandom_range(1, 65535));
            end
            write_register(CFG_CAPTURE_PERIOD, periods[ph]);
            write_register(CFG_OUTPUT_TOP, tops[ph]);
            burst_left = 0;
            for (n = 0; n < 240; n++)
            begin
                if (ph == 1 && n == 60)
                    hold_reqs++;
                if (ph == 4 && n == 120)
                    drain_results(0);
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    if ($urandom_range(0, 3) != 0)
                        idle($urandom_range(0, 12));
                end
                burst_left--;
                ch = 1'($urandom_range(0, 1));
                send_capture(ch, next_stamp(ch));
            end
            drain_results(80);
        end

        drain_results(100);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcmd_pkg.sv
rtl/pcmd_capture.sv
rtl/pcmd_sdiv.sv
rtl/pwm_capture_to_motor_drive_top.sv
tb/sv/pwm_capture_to_motor_drive_top_test.sv
